>>> design/icaf_pkg.sv
package icaf_pkg;

	localparam int CAL_SAMPLES  = 500;
	localparam int CORDIC_STEPS = 20;

	localparam int SUM_W  = 26;
	localparam int CNT_CAL_W = 10;
	localparam int DIV_STEPS = 1;
	// offset mean by reciprocal multiply: q = (n * DIV_RECIP) >> DIV_SH, exact for n < 2^SUM_W
	localparam int DIV_SH = SUM_W + $clog2(CAL_SAMPLES);
	localparam longint DIV_RECIP =
		((longint'(1) <<< DIV_SH) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
	localparam int SEQ_MAX = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
	localparam int SEQ_W  = $clog2(SEQ_MAX);
	localparam int XW     = 34;
	localparam int ZW     = 26;
	localparam int IDX_W  = 5;

	localparam logic [15:0] TIME_STEP_RST    = 16'd655;
	localparam logic [15:0] GYRO_WEIGHT_RST  = 16'd32113;
	localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd655;

	localparam logic [1:0] REG_TIME_STEP    = 2'd0;
	localparam logic [1:0] REG_GYRO_WEIGHT  = 2'd1;
	localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd2;

	typedef struct packed {
		logic [15:0] time_step;
		logic [15:0] gyro_weight;
		logic [15:0] accel_weight;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             cal_add;
		logic             div_init;
		logic             div_step;
		logic             div_done;
		logic             cor_init;
		logic             cor_step;
		logic [IDX_W-1:0] idx;
		logic             blend1;
		logic             blend2;
		logic             blend3;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic cal_hit;
		logic out_free;
	} sts_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZW-1:0] atan_tab(input logic [IDX_W-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> design/icaf_ctrl.sv
module icaf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  icaf_pkg::sts_t     sts,
	output icaf_pkg::cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CAL  = 4'd1;
	localparam logic [3:0] ST_DIVI = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_DFIN = 4'd4;
	localparam logic [3:0] ST_CINI = 4'd5;
	localparam logic [3:0] ST_COR  = 4'd6;
	localparam logic [3:0] ST_BL1  = 4'd7;
	localparam logic [3:0] ST_BL2  = 4'd8;
	localparam logic [3:0] ST_BL3  = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam logic [icaf_pkg::SEQ_W-1:0] DIV_LAST =
		icaf_pkg::SEQ_W'(icaf_pkg::DIV_STEPS - 1);
	localparam logic [icaf_pkg::SEQ_W-1:0] COR_LAST =
		icaf_pkg::SEQ_W'(icaf_pkg::CORDIC_STEPS - 1);

	logic [3:0]                    state_q, state_d;
	logic [icaf_pkg::SEQ_W-1:0]    cnt_q, cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = icaf_pkg::IDX_W'(cnt_q);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_op ? ST_CINI : ST_CAL;
				end
			end
			ST_CAL: begin
				cmd.cal_add = 1'b1;
				state_d     = sts.cal_hit ? ST_DIVI : ST_OUT;
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = ST_DFIN;
			end
			ST_DFIN: begin
				cmd.div_done = 1'b1;
				state_d      = ST_OUT;
			end
			ST_CINI: begin
				cmd.cor_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_COR;
			end
			ST_COR: begin
				cmd.cor_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == COR_LAST)
					state_d = ST_BL1;
			end
			ST_BL1: begin
				cmd.blend1 = 1'b1;
				state_d    = ST_BL2;
			end
			ST_BL2: begin
				cmd.blend2 = 1'b1;
				state_d    = ST_BL3;
			end
			ST_BL3: begin
				cmd.blend3 = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && $past(state_q) != ST_DIV) |-> $past(state_q) == ST_DIVI)
		else $error("divider entered without init");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= DIV_LAST)
		else $error("divider step count overrun");
	a_cor_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COR |-> cnt_q <= COR_LAST)
		else $error("cordic step count overrun");

endmodule

>>> design/icaf_dp.sv
module icaf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  icaf_pkg::cmd_t    cmd,
	input  icaf_pkg::cfg_t    cfg,
	input  logic [95:0]       in_data,
	input  logic              out_ready,
	output icaf_pkg::sts_t    sts,
	output logic              out_valid,
	output logic [103:0]      out_data
);

	localparam int SW = icaf_pkg::SUM_W;
	localparam int RW = icaf_pkg::SUM_W + 1;
	localparam int XW = icaf_pkg::XW;
	localparam int ZW = icaf_pkg::ZW;
	localparam logic [RW-1:0] RECIP = RW'(icaf_pkg::DIV_RECIP);
	localparam logic [SW-1:0] HALF  = SW'(icaf_pkg::CAL_SAMPLES / 2);
	localparam logic [icaf_pkg::CNT_CAL_W-1:0] CAL_N =
		icaf_pkg::CNT_CAL_W'(icaf_pkg::CAL_SAMPLES);
	localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] r_q [3];

	logic signed [SW-1:0] sums_q [3];
	logic [icaf_pkg::CNT_CAL_W-1:0] count_q, count_nxt;
	logic                 ready_q;
	logic signed [15:0]   off_q [3];
	logic                 neg_q [3];
	logic [SW-1:0]        num_q [3];

	logic signed [16:0]   g_q [3];
	logic signed [27:0]   inc_q [3];

	logic signed [XW-1:0] cx_q [2];
	logic signed [XW-1:0] cy_q [2];
	logic signed [ZW-1:0] cz_q [2];
	logic                 zero_q [2];

	logic signed [32:0]   inner_q [2];
	logic signed [49:0]   pa_q [2];
	logic signed [42:0]   pb_q [2];

	logic signed [31:0]   pitch_q, roll_q, yaw_q;
	logic                 ovalid_q;
	logic [103:0]         odata_q;

	// combinational next values
	logic signed [XW-1:0] ix [2];
	logic signed [XW-1:0] iy [2];
	logic signed [ZW-1:0] iz [2];
	logic                 izero [2];
	logic signed [XW-1:0] nx [2];
	logic signed [XW-1:0] ny [2];
	logic signed [ZW-1:0] nz [2];
	logic [SW+RW-1:0]     qprod [3];
	logic [SW-1:0]        mag [3];
	logic signed [33:0]   prod [3];

	assign count_nxt   = count_q + 1'b1;
	assign sts.cal_hit = (count_nxt == CAL_N);
	assign sts.out_free = !ovalid_q || out_ready;
	assign out_valid   = ovalid_q;
	assign out_data    = odata_q;

	always_comb begin
		logic signed [XW-1:0] sx, sy;
		for (int u = 0; u < 2; u++) begin
			sy = (u == 0) ? {{(XW-30){ay_q[15]}}, ay_q, 14'b0}
			              : {{(XW-30){ax_q[15]}}, ax_q, 14'b0};
			sx = {{(XW-30){az_q[15]}}, az_q, 14'b0};
			izero[u] = (sx == '0) && (sy == '0);
			if (sx < 0) begin
				if (sy >= 0) begin
					ix[u] = sy;
					iy[u] = -sx;
					iz[u] = DEG90;
				end else begin
					ix[u] = -sy;
					iy[u] = sx;
					iz[u] = -DEG90;
				end
			end else begin
				ix[u] = sx;
				iy[u] = sy;
				iz[u] = '0;
			end
			if (cy_q[u] >= 0) begin
				nx[u] = cx_q[u] + (cy_q[u] >>> cmd.idx);
				ny[u] = cy_q[u] - (cx_q[u] >>> cmd.idx);
				nz[u] = cz_q[u] + icaf_pkg::atan_tab(cmd.idx);
			end else begin
				nx[u] = cx_q[u] - (cy_q[u] >>> cmd.idx);
				ny[u] = cy_q[u] + (cx_q[u] >>> cmd.idx);
				nz[u] = cz_q[u] - icaf_pkg::atan_tab(cmd.idx);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qprod[k] = (SW+RW)'(num_q[k]) * (SW+RW)'(RECIP);
			mag[k]  = (sums_q[k] < 0) ? SW'(-sums_q[k]) : SW'(sums_q[k]);
			prod[k] = g_q[k] * $signed({1'b0, cfg.time_step});
		end
	end

	// input capture, divider, CORDIC, blend and output data datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= in_data[15:0];
			ay_q   <= in_data[31:16];
			az_q   <= in_data[47:32];
			r_q[0] <= in_data[63:48];
			r_q[1] <= in_data[79:64];
			r_q[2] <= in_data[95:80];
		end
		if (cmd.div_init) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= sums_q[k] < 0;
				num_q[k] <= mag[k] + HALF;
			end
		end
		// rounded magnitude times reciprocal gives the mean
		if (cmd.div_step) begin
			for (int k = 0; k < 3; k++)
				num_q[k] <= SW'(qprod[k][SW+RW-1:icaf_pkg::DIV_SH]);
		end
		if (cmd.cor_init) begin
			for (int k = 0; k < 3; k++)
				g_q[k] <= 17'(r_q[k]) - 17'(off_q[k]);
			for (int u = 0; u < 2; u++) begin
				cx_q[u]   <= ix[u];
				cy_q[u]   <= iy[u];
				cz_q[u]   <= iz[u];
				zero_q[u] <= izero[u];
			end
		end
		if (cmd.cor_step) begin
			for (int k = 0; k < 3; k++)
				inc_q[k] <= 28'((prod[k] + 34'sd32) >>> 6);
			for (int u = 0; u < 2; u++) begin
				cx_q[u] <= nx[u];
				cy_q[u] <= ny[u];
				cz_q[u] <= nz[u];
			end
		end
		if (cmd.blend1) begin
			inner_q[0] <= 33'(pitch_q) + 33'(inc_q[0]);
			inner_q[1] <= 33'(roll_q) + 33'(inc_q[1]);
		end
		if (cmd.blend2) begin
			for (int u = 0; u < 2; u++) begin
				pa_q[u] <= $signed({1'b0, cfg.gyro_weight}) * inner_q[u];
				pb_q[u] <= $signed({1'b0, cfg.accel_weight}) *
				           $signed(zero_q[u] ? '0 : cz_q[u]);
			end
		end
		if (cmd.out_load)
			odata_q <= {7'b0, ready_q, yaw_q, roll_q, pitch_q};
	end

	// filter state, calibration state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [50:0] t0, t1;
		if (!arst_n) begin
			pitch_q  <= '0;
			roll_q   <= '0;
			yaw_q    <= '0;
			count_q  <= '0;
			ready_q  <= 1'b0;
			ovalid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sums_q[k] <= '0;
				off_q[k]  <= '0;
			end
		end else begin
			t0 = 51'(pa_q[0]) + 51'(pb_q[0]) + 51'sd16384;
			t1 = 51'(pa_q[1]) + 51'(pb_q[1]) + 51'sd16384;
			if (cmd.cal_add) begin
				count_q <= count_nxt;
				for (int k = 0; k < 3; k++)
					sums_q[k] <= sums_q[k] + SW'(r_q[k]);
			end
			if (cmd.div_done) begin
				count_q <= '0;
				ready_q <= 1'b1;
				for (int k = 0; k < 3; k++) begin
					sums_q[k] <= '0;
					off_q[k]  <= neg_q[k] ? -num_q[k][15:0] : num_q[k][15:0];
				end
			end
			if (cmd.blend1)
				yaw_q <= icaf_pkg::sat32(36'(yaw_q) + 36'(inc_q[2]));
			if (cmd.blend3) begin
				pitch_q <= icaf_pkg::sat32(36'(t0 >>> 15));
				roll_q  <= icaf_pkg::sat32(36'(t1 >>> 15));
			end
			if (cmd.out_load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	a_cal_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_done |=> ready_q && count_q == '0)
		else $error("calibration finish did not clear count or set flag");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> ovalid_q)
		else $error("result load lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ovalid_q || out_ready))
		else $error("result overwritten before taken");

endmodule

>>> design/imu_complementary_attitude_filter_core.sv
// channel   | dir | signals                 | contents (lsb first)
// s_axis    | in  | tvalid tready tdata tuser | tdata: accel x,y,z, rate x,y,z; tuser: op
// m_axis    | out | tvalid tready tdata      | tdata: pitch, roll, yaw, offsets_ready
// apb       | in  | psel penable pwrite ...  | 0x0 time_step, 0x4 gyro_weight, 0x8 accel_weight
//
// Filter item: input capture, CORDIC init, 20 CORDIC iterations (these dominate), the blend
// steps, then output load.
// Calibration item: input capture and accumulate; when a batch completes, divider init, reciprocal
// multiply for the mean and finish follow before output load.
// One item in flight; the next is taken once its result sits in the output register.
// A stalled m_axis holds the result and blocks completion of the following item.
// Reset clears angles, offsets, sums, count and ready flag; registers go to defaults.
module imu_complementary_attitude_filter_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic         s_axis_tuser,   // op: 0 calibration, 1 filter
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // pitch_angle, roll_angle, yaw_angle, offsets_ready
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	icaf_pkg::cfg_t cfg_q;
	icaf_pkg::cmd_t cmd;
	icaf_pkg::sts_t sts;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file; writes keep the low 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step    <= icaf_pkg::TIME_STEP_RST;
			cfg_q.gyro_weight  <= icaf_pkg::GYRO_WEIGHT_RST;
			cfg_q.accel_weight <= icaf_pkg::ACCEL_WEIGHT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				icaf_pkg::REG_TIME_STEP:    cfg_q.time_step    <= pwdata[15:0];
				icaf_pkg::REG_GYRO_WEIGHT:  cfg_q.gyro_weight  <= pwdata[15:0];
				icaf_pkg::REG_ACCEL_WEIGHT: cfg_q.accel_weight <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			icaf_pkg::REG_TIME_STEP:    prdata = {16'b0, cfg_q.time_step};
			icaf_pkg::REG_GYRO_WEIGHT:  prdata = {16'b0, cfg_q.gyro_weight};
			icaf_pkg::REG_ACCEL_WEIGHT: prdata = {16'b0, cfg_q.accel_weight};
			default:                    prdata = '0;
		endcase
	end

	icaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icaf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule
